/* hdl/cmsp_pkg.sv */
// ----------------------------------------------------------------------------
// cmsp_pkg
// Types and constants shared by the CPU mask string parser.
// ----------------------------------------------------------------------------
package cmsp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [63:0] mask_word;
      logic [1:0]  word_index;
      logic        last_word;
      logic [2:0]  format;
      logic [1:0]  status;
   } rsp_type;

   // format codes
   localparam logic [2:0] FMT_NONE  = 3'd0;
   localparam logic [2:0] FMT_RANGE = 3'd1;
   localparam logic [2:0] FMT_BIN   = 3'd2;
   localparam logic [2:0] FMT_HEX   = 3'd3;
   localparam logic [2:0] FMT_TRAIL = 3'd4;

   // status codes
   localparam logic [1:0] ST_NONEMPTY = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;

   // candidate bit positions
   localparam int CAND_P01 = 0;
   localparam int CAND_BIN = 1;
   localparam int CAND_HEX = 2;
   localparam int CAND_RNG = 3;
   localparam logic [3:0] CAND_ALL = 4'hF;

   localparam logic [8:0] CPU_TOTAL_RESET = 9'd256;

   // characters
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LB    = 8'h62;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;

endpackage

/* hdl/cmsp_front.sv */
// ----------------------------------------------------------------------------
// cmsp_front
// Per-character parser; at the last character builds the final masked mask.
// ----------------------------------------------------------------------------
module cmsp_front #(
   parameter int MASK_BITS = 256,
   parameter int MAX_CHARS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_take,
   input  cmsp_pkg::req_type      in_data,
   input  logic [8:0]             cpu_total,
   output logic                   push,
   output logic [MASK_BITS+4:0]   push_data
);
   import cmsp_pkg::*;

   localparam int CW = $clog2(MAX_CHARS + 2);
   localparam int NW = $clog2(MASK_BITS + 1);

   typedef enum logic [1:0] {PH_SKIP, PH_START, PH_DASH, PH_END} phase_type;

   phase_type            phase_ff, phase_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [3:0]           cand_ff, cand_in;
   logic [NW-1:0]        start_ff, start_in, end_ff, end_in;
   logic [MASK_BITS-1:0] range_ff, range_in, pos_ff, pos_in, shift_ff, shift_in;

   logic [7:0]           c;
   logic                 isdig, is01, isb, isx, hv_ok, bin_ok, hex_ok, rng_ok, old_ok;
   logic [3:0]           hv;
   logic                 set_now, apply_now, too_long;
   logic [MASK_BITS-1:0] range_hit, pos_hit, eff_mask, src, final_mask;
   logic [2:0]           fmt;
   logic [1:0]           status;
   logic [31:0]          eff;

   function automatic logic [NW-1:0] acc10(input logic [NW-1:0] a, input logic [3:0] d);
      logic [NW+3:0] v;
      v = (NW+4)'(a) * (NW+4)'(10) + (NW+4)'(d);
      return (v > (NW+4)'(MASK_BITS)) ? NW'(MASK_BITS) : v[NW-1:0];
   endfunction

   assign c     = in_data.char_code;
   assign isdig = (c >= CH_0) && (c <= CH_9);
   assign is01  = (c == CH_0) || (c == CH_1);
   assign isb   = (c == CH_LB) || (c == CH_UB);
   assign isx   = (c == CH_LX) || (c == CH_UX);

   always_comb begin
      hv_ok = 1'b1;
      hv    = c[3:0];
      priority if (isdig) begin
         hv = c[3:0];
      end else if (c >= CH_LA && c <= CH_LF) begin
         hv = 4'(c - CH_LA + 8'd10);
      end else if (c >= CH_UA && c <= CH_UF) begin
         hv = 4'(c - CH_UA + 8'd10);
      end else begin
         hv_ok = 1'b0;
      end
   end

   // shift register for 0b / 0x forms
   always_comb begin
      shift_in = shift_ff;
      if (count_ff >= CW'(2)) begin
         if (cand_ff[CAND_BIN] && is01) begin
            shift_in = {shift_ff[MASK_BITS-2:0], c[0]};
         end else if (cand_ff[CAND_HEX] && hv_ok) begin
            shift_in = {shift_ff[MASK_BITS-5:0], hv};
         end
      end
   end

   // range list walker
   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      set_now   = 1'b0;
      apply_now = 1'b0;
      unique case (phase_ff)
         PH_SKIP: begin
            if (isdig) begin
               start_in = NW'(c[3:0]);
               phase_in = PH_START;
            end
         end
         PH_START: begin
            if (isdig) begin
               start_in = acc10(start_ff, c[3:0]);
            end else if (c == CH_COMMA) begin
               set_now  = 1'b1;
               phase_in = PH_SKIP;
            end else if (c == CH_DASH) begin
               phase_in = PH_DASH;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_DASH: begin
            if (isdig) begin
               end_in   = NW'(c[3:0]);
               phase_in = PH_END;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_END: begin
            if (isdig) begin
               end_in = acc10(end_ff, c[3:0]);
            end else begin
               apply_now = 1'b1;
               phase_in  = PH_SKIP;
            end
         end
         default: phase_in = PH_SKIP;
      endcase
      // pending number or range closes at end of string
      if (in_data.last_char) begin
         if (phase_in == PH_START) begin
            set_now = 1'b1;
         end else if (phase_in == PH_END) begin
            apply_now = 1'b1;
         end
      end
   end

   assign eff = (cpu_total == 9'd0 || 32'(cpu_total) > MASK_BITS) ? MASK_BITS : 32'(cpu_total);

   for (genvar i = 0; i < MASK_BITS; i++) begin : g_bit
      assign range_hit[i] = (set_now && 32'(start_in) == i) ||
                            (apply_now && (end_in > start_in) &&
                             32'(start_in) <= i && i <= 32'(end_in));
      assign pos_hit[i]   = (c == CH_1) && (32'(count_ff) == i);
      assign eff_mask[i]  = i < eff;
   end

   assign range_in = range_ff | range_hit;
   assign pos_in   = pos_ff | pos_hit;

   always_comb begin
      unique case (count_ff)
         CW'(0):  begin
            bin_ok = (c == CH_0);
            hex_ok = (c == CH_0);
         end
         CW'(1):  begin
            bin_ok = isb;
            hex_ok = isx;
         end
         default: begin
            bin_ok = is01;
            hex_ok = hv_ok;
         end
      endcase
   end

   assign rng_ok   = isdig || (c == CH_COMMA) || (c == CH_DASH);
   assign cand_in  = cand_ff & {rng_ok, hex_ok, bin_ok, is01};
   assign count_in = (count_ff <= CW'(MAX_CHARS)) ? count_ff + CW'(1) : count_ff;
   assign old_ok   = cand_ff[CAND_P01] && isb && (count_ff >= CW'(2));
   assign too_long = count_in > CW'(MAX_CHARS);

   always_comb begin
      src = '0;
      priority if (too_long) begin
         fmt = FMT_NONE;
      end else if (old_ok) begin
         fmt = FMT_TRAIL;
         src = pos_in;
      end else if (cand_in[CAND_BIN] && count_in >= CW'(3)) begin
         fmt = FMT_BIN;
         src = shift_in;
      end else if (cand_in[CAND_HEX] && count_in >= CW'(3)) begin
         fmt = FMT_HEX;
         src = shift_in;
      end else if (cand_in[CAND_RNG]) begin
         fmt = FMT_RANGE;
         src = range_in;
      end else begin
         fmt = FMT_NONE;
      end
   end

   assign final_mask = src & eff_mask;
   assign status     = too_long ? ST_TOO_LONG : ((|final_mask) ? ST_NONEMPTY : ST_EMPTY);
   assign push       = in_take && in_data.last_char;
   assign push_data  = {final_mask, fmt, status};

   always_ff @(posedge clock) begin
      if (reset || push) begin
         phase_ff <= PH_SKIP;
         count_ff <= '0;
         cand_ff  <= CAND_ALL;
         start_ff <= '0;
         end_ff   <= '0;
         range_ff <= '0;
         pos_ff   <= '0;
         shift_ff <= '0;
      end else if (in_take) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         cand_ff  <= cand_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         range_ff <= range_in;
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

endmodule

/* hdl/cmsp_queue.sv */
// ----------------------------------------------------------------------------
// cmsp_queue
// Two-entry queue of finished masks between parser and word sender.
// ----------------------------------------------------------------------------
module cmsp_queue #(
   parameter int WIDTH = 261
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             full,
   output logic             empty
);
   logic [1:0][WIDTH-1:0] slot_ff;
   logic                  wr_ff, rd_ff;
   logic [1:0]            cnt_ff;

   assign head  = slot_ff[rd_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= ~wr_ff;
         end
         if (pop) begin
            rd_ff <= ~rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

/* hdl/cmsp_back.sv */
// ----------------------------------------------------------------------------
// cmsp_back
// Sends the queue head mask as a train of 64-bit words.
// ----------------------------------------------------------------------------
module cmsp_back #(
   parameter int MASK_BITS = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [MASK_BITS+4:0] head,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cmsp_pkg::rsp_type    rsp_data
);
   import cmsp_pkg::*;

   localparam int WORDS = MASK_BITS / 64;
   localparam int WCW   = (WORDS > 1) ? $clog2(WORDS) : 1;

   logic [WORDS-1:0][63:0] words;
   logic [WCW-1:0]         word_ff;
   logic                   at_last, xfer;

   assign words     = head[MASK_BITS+4:5];
   assign at_last   = word_ff == WCW'(WORDS - 1);
   assign rsp_valid = !empty;
   assign xfer      = rsp_valid && !rsp_stall;
   assign pop       = xfer && at_last;

   always_comb begin
      rsp_data.mask_word  = words[word_ff];
      rsp_data.word_index = 2'(word_ff);
      rsp_data.last_word  = at_last;
      rsp_data.format     = head[4:2];
      rsp_data.status     = head[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
      end else if (xfer) begin
         word_ff <= at_last ? '0 : word_ff + WCW'(1);
      end
   end

endmodule

/* hdl/cpu_mask_string_parser.sv */
// ----------------------------------------------------------------------------
// cpu_mask_string_parser
// Builds a CPU bit mask from a character stream and sends it as 64-bit words.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// req_    | in  | req_valid/stall   | req_type: char_code, last_char
// rsp_    | out | rsp_valid/stall   | rsp_type: mask word, index, format, status
// csr_    | in  | csr_valid/ready   | cpu_total (9 bits)
//
// One character is taken per cycle while req_stall is low; the parser state
// updates in that cycle. The last character pushes the finished, size-limited
// mask into a 2-deep queue; the sender drains it at one word per cycle while
// rsp_stall is low. req_stall rises only while the queue is full.
// Reset is synchronous: parser cleared, queue empty, cpu_total = 256.
// ----------------------------------------------------------------------------
module cpu_mask_string_parser #(
   parameter int MASK_BITS = 256,
   parameter int MAX_CHARS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cmsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cmsp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [8:0]        csr_data
);
   import cmsp_pkg::*;

   logic [8:0]           cpu_total_ff;
   logic                 push, pop, q_full, q_empty, take;
   logic [MASK_BITS+4:0] push_data, head;

   // config register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_total_ff <= CPU_TOTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         cpu_total_ff <= csr_data;
      end
   end

   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   cmsp_front #(.MASK_BITS(MASK_BITS), .MAX_CHARS(MAX_CHARS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_take   (take),
      .in_data   (req_data),
      .cpu_total (cpu_total_ff),
      .push      (push),
      .push_data (push_data)
   );

   cmsp_queue #(.WIDTH(MASK_BITS + 5)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   cmsp_back #(.MASK_BITS(MASK_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/cmsp_checker.sv */
// ----------------------------------------------------------------------------
// cmsp_checker
// Port-level checks on the result word train.
// ----------------------------------------------------------------------------
module cmsp_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cmsp_pkg::rsp_type rsp_data
);
   import cmsp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_next_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_index == 2'($past(rsp_data.word_index) + 2'd1))
      else $error("word train broken");

   a_same_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         $stable(rsp_data.format) && $stable(rsp_data.status))
      else $error("format or status changed inside one mask");

   a_new_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last_word |=>
         !rsp_valid || rsp_data.word_index == 2'd0)
      else $error("mask does not start at word zero");

endmodule

bind cpu_mask_string_parser cmsp_checker u_cmsp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
